@@ rtl/core/embgm_pkg.sv @@
`timescale 1ns / 1ps

package embgm_pkg;

    // Accumulator / similarity width, Q8.30
    localparam int ACC_W = 38;
    localparam int THR_W = 32;
    localparam int SLOT_FIELD_W = 6;
    localparam int QUAL_W = 16;
    localparam int OP_W = 3;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic signed [THR_W-1:0] THRESH_RESET = 32'sd536870912;

    // improve rule: new * 20 > stored * 23
    localparam int Q_NUM = 20;
    localparam int Q_DEN = 23;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_ASSIGN   = 3'd0;
    localparam t_op OP_IMPROVE  = 3'd1;
    localparam t_op OP_IDENTIFY = 3'd2;
    localparam t_op OP_RESET    = 3'd3;
    localparam t_op OP_REMOVE   = 3'd4;
    localparam t_op OP_ADD      = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    // control that travels with one MAC beat
    typedef struct packed {
        logic valid;
        logic enrolled;
        logic first;   // first element: previous accumulator reads as zero
        logic track;   // last full element: track the running best
    } t_mac_ctl;

endpackage

@@ rtl/core/embgm_mac.sv @@
`timescale 1ns / 1ps

module embgm_mac
    import embgm_pkg::*;
#(
    parameter int ELEMENT_BITS = 16,
    parameter int SLOT_W = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_mac_ctl                       i_ctl,
    input  logic [SLOT_W-1:0]              i_slot,
    input  logic signed [ELEMENT_BITS-1:0] i_elem,
    input  logic signed [ELEMENT_BITS-1:0] i_gal,
    input  logic signed [ACC_W-1:0]        i_acc,
    input  logic                           i_best_init,
    input  logic signed [THR_W-1:0]        i_thresh,
    output logic                           o_busy,
    output logic                           o_acc_we,
    output logic [SLOT_W-1:0]              o_acc_slot,
    output logic signed [ACC_W-1:0]        o_acc_data,
    output logic                           o_found,
    output logic [SLOT_W-1:0]              o_best_slot,
    output logic signed [ACC_W-1:0]        o_best,
    output logic                           o_match
);

    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
    localparam int BEST_W = (PROD_W - 1 > ACC_W) ? PROD_W - 1 : ACC_W;
    localparam logic signed [BEST_W-1:0] MINUS_ONE =
        BEST_W'(-(64'sd1 <<< (PROD_W - 2)));

    t_mac_ctl                   r_ctl;
    logic [SLOT_W-1:0]          r_slot;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [BEST_W-1:0]   r_best;
    logic                       r_found;
    logic [SLOT_W-1:0]          r_best_slot;

    logic signed [SUM_W-1:0]    w_sum;
    logic signed [ACC_W-1:0]    w_sat;
    logic signed [ACC_W-1:0]    w_prev;

    // stage A: product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_slot <= i_slot;
        r_prod <= i_elem * i_gal;
        r_acc  <= i_acc;
    end

    // stage B: saturating accumulate
    always_comb begin
        w_prev = r_ctl.first ? '0 : r_acc;
        w_sum  = SUM_W'(r_prod) + SUM_W'(w_prev);
        if (w_sum > SUM_W'(ACC_MAX)) begin
            w_sat = ACC_MAX;
        end else if (w_sum < SUM_W'(ACC_MIN)) begin
            w_sat = ACC_MIN;
        end else begin
            w_sat = ACC_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_best_init) begin
            r_found <= 1'b0;
        end else if (r_ctl.valid && r_ctl.enrolled && r_ctl.track &&
                     BEST_W'(w_sat) > r_best) begin
            r_found <= 1'b1;
        end
        if (i_best_init) begin
            r_best      <= MINUS_ONE;
            r_best_slot <= '0;
        end else if (r_ctl.valid && r_ctl.enrolled && r_ctl.track &&
                     BEST_W'(w_sat) > r_best) begin
            r_best      <= BEST_W'(w_sat);
            r_best_slot <= r_slot;
        end
    end

    assign o_busy      = r_ctl.valid;
    assign o_acc_we    = r_ctl.valid && r_ctl.enrolled;
    assign o_acc_slot  = r_slot;
    assign o_acc_data  = w_sat;
    assign o_found     = r_found;
    assign o_best_slot = r_best_slot;
    assign o_best      = ACC_W'(r_best);
    assign o_match     = r_found && (r_best >= BEST_W'(i_thresh));

endmodule

@@ rtl/core/embedding_gallery_matcher.sv @@
`timescale 1ns / 1ps

// Embedding gallery matcher: SLOT_COUNT slots, each with present/enrolled
// flags, a 16-bit quality and an EMBED_DIM-element signed Q1.15 embedding.
// Vector ops (assign, improve, identify) stream one element per input beat
// up to last_element (or position EMBED_DIM-1); reset/remove/add slot act on
// one beat. One result beat per single op and per finished vector.
// Every input beat passes through accept and execute; improve's quality check
// rides in the execute step. Each identify element runs through accept,
// execute and one sweep of the single shared multiply-accumulate over all
// slots, one slot a cycle, then a drain of the MAC pipe. The last element of
// a full identify adds a result step, since the best-score scan is folded
// into its sweep. A result that cannot leave because the output is stalled
// holds the block in execute (or in the identify result step). No clearing
// pass: accumulators restart at the first element, gallery and quality
// storage are only used for enrolled slots. match_threshold (Q2.30) is
// written via i_cfg_wr_en/i_cfg_wr_data; the user must do so only while
// idle, the block itself does not enforce it.

module embedding_gallery_matcher
    import embgm_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int EMBED_DIM = 128,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [OP_W-1:0]                i_operation,
    input  logic [SLOT_FIELD_W-1:0]        i_slot,
    input  logic signed [ELEMENT_BITS-1:0] i_element_value,
    input  logic [QUAL_W-1:0]              i_quality,
    input  logic                           i_last_element,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [SLOT_FIELD_W-1:0]        o_result_slot,
    output logic signed [ACC_W-1:0]        o_similarity,
    output logic                           o_matched,
    output logic                           o_accepted,
    input  logic                           i_cfg_wr_en,
    input  logic signed [THR_W-1:0]        i_cfg_wr_data
);

    localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW   = $clog2(EMBED_DIM);
    localparam int GD   = SLOT_COUNT * EMBED_DIM;
    localparam int GA_W = $clog2(GD);

    t_state r_state, n_state;

    // latched input beat
    t_op                            r_op;
    logic [SLOT_FIELD_W-1:0]        r_slot;
    logic signed [ELEMENT_BITS-1:0] r_ev;
    logic [QUAL_W-1:0]              r_q;
    logic                           r_last;
    logic [QUAL_W-1:0]              r_qrd;

    // vector context
    logic [PW-1:0]           r_pos, n_pos;
    t_op                     r_hop, n_hop;
    logic [SLOT_FIELD_W-1:0] r_hslot, n_hslot;
    logic [QUAL_W-1:0]       r_hq, n_hq;
    logic                    r_grant, n_grant;

    logic [SLOT_COUNT-1:0] r_present, n_present;
    logic [SLOT_COUNT-1:0] r_enrolled, n_enrolled;
    logic signed [THR_W-1:0] r_thresh;

    // storage
    logic [QUAL_W-1:0]              m_quality [SLOT_COUNT];
    logic signed [ELEMENT_BITS-1:0] m_gallery [GD];
    logic signed [ACC_W-1:0]        m_acc     [SLOT_COUNT];

    // sweep
    logic [SW:0]     r_sc, n_sc;
    logic [GA_W-1:0] r_gaddr, n_gaddr;
    logic            r_first, n_first;
    logic            r_track, n_track;
    logic            r_endv, n_endv;
    logic            r_v1;
    logic [SW-1:0]   r_s1slot;
    logic            r_s1en;
    logic signed [ELEMENT_BITS-1:0] r_grd;
    logic signed [ACC_W-1:0]        r_ard;
    logic            w_issue;
    logic            w_best_init;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic [SLOT_FIELD_W-1:0] r_out_slot, n_out_slot;
    logic signed [ACC_W-1:0] r_out_sim, n_out_sim;
    logic                    r_out_match, n_out_match;
    logic                    r_out_acc, n_out_acc;

    // execute-stage decode
    logic                    w_accept, w_out_free, w_start, w_ok, w_single;
    logic                    w_full, w_endv, w_grant_new, w_grant, w_emit, w_better_q;
    t_op                     w_vop;
    logic [SLOT_FIELD_W-1:0] w_vslot;
    logic [QUAL_W-1:0]       w_vq;
    logic [SW-1:0]           w_sidx, w_vidx;
    logic                    w_qwe;
    logic [QUAL_W-1:0]       w_qwdata;
    logic                    w_gwe;
    logic [GA_W-1:0]         w_gwaddr;

    // MAC signals
    t_mac_ctl                w_ctl;
    logic                    w_mac_busy, w_acc_we, w_found, w_match;
    logic [SW-1:0]           w_acc_slot, w_best_slot;
    logic signed [ACC_W-1:0] w_acc_data, w_best;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_operation;
            r_slot <= i_slot;
            r_ev   <= i_element_value;
            r_q    <= i_quality;
            r_last <= i_last_element;
            r_qrd  <= m_quality[SW'(i_slot)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_thresh <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_start    = (r_pos == '0);
        w_ok       = (32'(r_slot) < SLOT_COUNT);
        w_sidx     = SW'(r_slot);
        w_single   = w_start && !(r_op == OP_ASSIGN || r_op == OP_IMPROVE ||
                                  r_op == OP_IDENTIFY);
        w_vop      = w_start ? r_op : r_hop;
        w_vslot    = w_start ? r_slot : r_hslot;
        w_vq       = w_start ? r_q : r_hq;
        w_vidx     = SW'(w_vslot);
        w_full     = (r_pos == PW'(EMBED_DIM - 1));
        w_endv     = r_last || w_full;
        w_better_q = (21'(r_q) * 21'(Q_NUM)) > (21'(r_qrd) * 21'(Q_DEN));
        case (r_op)
            OP_ASSIGN:  w_grant_new = w_ok;
            OP_IMPROVE: w_grant_new = w_ok && r_present[w_sidx] &&
                                      (!r_enrolled[w_sidx] || w_better_q);
            default:    w_grant_new = 1'b0;
        endcase
        w_grant = w_start ? w_grant_new : r_grant;
        w_emit  = w_single || (w_endv && (w_vop != OP_IDENTIFY || !w_full));
        w_gwaddr = GA_W'(GA_W'(w_vidx) * GA_W'(EMBED_DIM)) + GA_W'(r_pos);
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_hop       = r_hop;
        n_hslot     = r_hslot;
        n_hq        = r_hq;
        n_grant     = r_grant;
        n_present   = r_present;
        n_enrolled  = r_enrolled;
        n_sc        = r_sc;
        n_gaddr     = r_gaddr;
        n_first     = r_first;
        n_track     = r_track;
        n_endv      = r_endv;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_slot  = r_out_slot;
        n_out_sim   = r_out_sim;
        n_out_match = r_out_match;
        n_out_acc   = r_out_acc;
        w_qwe       = 1'b0;
        w_qwdata    = '0;
        w_gwe       = 1'b0;
        w_issue     = 1'b0;
        w_best_init = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!(w_emit && !w_out_free)) begin
                    n_state = S_IDLE;
                    if (w_single) begin
                        n_out_valid = 1'b1;
                        n_out_slot  = r_slot;
                        n_out_sim   = '0;
                        n_out_match = 1'b0;
                        n_out_acc   = 1'b0;
                        case (r_op)
                            OP_RESET: begin
                                if (w_ok && r_present[w_sidx]) begin
                                    n_enrolled[w_sidx] = 1'b0;
                                    w_qwe     = 1'b1;
                                    n_out_acc = 1'b1;
                                end
                            end
                            OP_REMOVE: begin
                                if (w_ok && r_present[w_sidx]) begin
                                    n_present[w_sidx]  = 1'b0;
                                    n_enrolled[w_sidx] = 1'b0;
                                    w_qwe     = 1'b1;
                                    n_out_acc = 1'b1;
                                end
                            end
                            OP_ADD: begin
                                if (w_ok && !r_present[w_sidx]) begin
                                    n_present[w_sidx] = 1'b1;
                                    n_out_acc = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end else begin
                        if (w_start) begin
                            n_hop   = r_op;
                            n_hslot = r_slot;
                            n_hq    = r_q;
                            n_grant = w_grant_new;
                            if (w_grant_new) begin
                                n_enrolled[w_sidx] = 1'b0;
                            end
                        end
                        if (w_vop != OP_IDENTIFY) begin
                            w_gwe = w_grant;
                            if (w_endv) begin
                                if (w_grant) begin
                                    w_qwe = 1'b1;
                                    if (w_full) begin
                                        n_present[w_vidx]  = 1'b1;
                                        n_enrolled[w_vidx] = 1'b1;
                                        w_qwdata = w_vq;
                                    end
                                end
                                n_out_valid = 1'b1;
                                n_out_slot  = w_vslot;
                                n_out_sim   = '0;
                                n_out_match = 1'b0;
                                n_out_acc   = w_grant && w_full;
                                n_pos   = '0;
                                n_grant = 1'b0;
                            end else begin
                                n_pos = r_pos + 1'b1;
                            end
                        end else if (w_endv && !w_full) begin
                            // short identify: aborted
                            n_out_valid = 1'b1;
                            n_out_slot  = '0;
                            n_out_sim   = '0;
                            n_out_match = 1'b0;
                            n_out_acc   = 1'b0;
                            n_pos       = '0;
                        end else begin
                            n_state     = S_SWEEP;
                            n_sc        = '0;
                            n_gaddr     = GA_W'(r_pos);
                            n_first     = w_start;
                            n_track     = w_full;
                            n_endv      = w_endv;
                            w_best_init = 1'b1;
                        end
                    end
                end
            end
            S_SWEEP: begin
                if (r_sc != (SW+1)'(SLOT_COUNT)) begin
                    w_issue = 1'b1;
                    n_sc    = r_sc + 1'b1;
                    n_gaddr = r_gaddr + GA_W'(EMBED_DIM);
                end else if (!r_v1 && !w_mac_busy) begin
                    if (r_endv) begin
                        n_state = S_FIN;
                        n_pos   = '0;
                    end else begin
                        n_state = S_IDLE;
                        n_pos   = r_pos + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_slot  = w_found ? SLOT_FIELD_W'(w_best_slot) : '0;
                    n_out_sim   = w_match ? w_best : '0;
                    n_out_match = w_match;
                    n_out_acc   = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_hop       <= OP_ASSIGN;
            r_hslot     <= '0;
            r_hq        <= '0;
            r_grant     <= 1'b0;
            r_present   <= '0;
            r_enrolled  <= '0;
            r_sc        <= '0;
            r_first     <= 1'b0;
            r_track     <= 1'b0;
            r_endv      <= 1'b0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_hop       <= n_hop;
            r_hslot     <= n_hslot;
            r_hq        <= n_hq;
            r_grant     <= n_grant;
            r_present   <= n_present;
            r_enrolled  <= n_enrolled;
            r_sc        <= n_sc;
            r_first     <= n_first;
            r_track     <= n_track;
            r_endv      <= n_endv;
            r_out_valid <= n_out_valid;
            r_v1        <= w_issue;
        end
        r_gaddr     <= n_gaddr;
        r_out_slot  <= n_out_slot;
        r_out_sim   <= n_out_sim;
        r_out_match <= n_out_match;
        r_out_acc   <= n_out_acc;
    end

    // quality store: write in execute, read at accept
    always_ff @(posedge i_clk) begin
        if (w_qwe) begin
            m_quality[w_vidx] <= w_qwdata;
        end
    end

    // gallery: one write per granted assign/improve element, one read per sweep beat
    always_ff @(posedge i_clk) begin
        if (w_gwe) begin
            m_gallery[w_gwaddr] <= r_ev;
        end
        r_grd <= m_gallery[r_gaddr];
    end

    // accumulators: read at issue, written back from the MAC
    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            m_acc[w_acc_slot] <= w_acc_data;
        end
        r_ard    <= m_acc[r_sc[SW-1:0]];
        r_s1slot <= r_sc[SW-1:0];
        r_s1en   <= r_enrolled[r_sc[SW-1:0]];
    end

    always_comb begin
        w_ctl.valid    = r_v1;
        w_ctl.enrolled = r_s1en;
        w_ctl.first    = r_first;
        w_ctl.track    = r_track;
    end

    embgm_mac #(
        .ELEMENT_BITS(ELEMENT_BITS),
        .SLOT_W(SW)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_slot      (r_s1slot),
        .i_elem      (r_ev),
        .i_gal       (r_grd),
        .i_acc       (r_ard),
        .i_best_init (w_best_init),
        .i_thresh    (r_thresh),
        .o_busy      (w_mac_busy),
        .o_acc_we    (w_acc_we),
        .o_acc_slot  (w_acc_slot),
        .o_acc_data  (w_acc_data),
        .o_found     (w_found),
        .o_best_slot (w_best_slot),
        .o_best      (w_best),
        .o_match     (w_match)
    );

    assign o_out_valid   = r_out_valid;
    assign o_result_slot = r_out_slot;
    assign o_similarity  = r_out_sim;
    assign o_matched     = r_out_match;
    assign o_accepted    = r_out_acc;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import embgm_pkg::*;

    localparam int SLOTS       = 64;
    localparam int DIM         = 128;
    localparam int EL_W        = 16;
    localparam int CYCLE_CAP   = 3000000;
    localparam int HOLD_LEN    = 3000;
    localparam int DRAIN_WAIT  = SLOTS + 12;
    localparam int PHASE_BEATS = 100;
    localparam longint MINUS_ONE_Q30 = -(64'sd1 <<< 30);

    typedef struct {
        logic [SLOT_FIELD_W-1:0] slot;
        logic signed [ACC_W-1:0] sim;
        bit                      matched;
        bit                      accepted;
    } match_result_t;

    // one directed row: a single op or a whole vector filled with one value
    typedef struct {
        t_op           op;
        int            slot;
        int            len;
        int            ev;
        int            qual;
        bit            no_last;   // long vector: ends on position DIM-1 alone
        bit            typed;
        match_result_t want;
    } dir_row_t;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [OP_W-1:0]                i_operation = '0;
    logic [SLOT_FIELD_W-1:0]        i_slot = '0;
    logic signed [EL_W-1:0]         i_element_value = '0;
    logic [QUAL_W-1:0]              i_quality = '0;
    logic                           i_last_element = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [SLOT_FIELD_W-1:0]        o_result_slot;
    logic signed [ACC_W-1:0]        o_similarity;
    logic                           o_matched;
    logic                           o_accepted;
    logic                           i_cfg_wr_en = 1'b0;
    logic signed [THR_W-1:0]        i_cfg_wr_data = '0;

    embedding_gallery_matcher #(
        .SLOT_COUNT  (SLOTS),
        .EMBED_DIM   (DIM),
        .ELEMENT_BITS(EL_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_slot         (i_slot),
        .i_element_value(i_element_value),
        .i_quality      (i_quality),
        .i_last_element (i_last_element),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_slot  (o_result_slot),
        .o_similarity   (o_similarity),
        .o_matched      (o_matched),
        .o_accepted     (o_accepted),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Gallery predictor: own copy of slots, flags and accumulators
    // ---------------------------------------------------------------
    logic signed [EL_W-1:0]  gallery_mem [SLOTS][DIM];
    bit                      present_f   [SLOTS];
    bit                      enrolled_f  [SLOTS];
    logic [QUAL_W-1:0]       quality_f   [SLOTS];
    longint                  score_acc   [SLOTS];
    int                      vec_pos;
    bit                      write_ok;
    t_op                     held_op;
    int                      held_slot;
    logic [QUAL_W-1:0]       held_qual;
    longint                  thr_q30;

    match_result_t pending_results[$];

    int  mismatches;
    int  beats_in;
    int  results_seen;
    int  matches_seen;
    int  cycles;
    bit  hold_request;
    int  burst_left;

    // Advances the predictor by one input beat; returns 1 when a result leaves.
    function automatic bit gallery_step(input t_op op, input int sl,
                                        input logic signed [EL_W-1:0] ev,
                                        input logic [QUAL_W-1:0] q, input bit lst,
                                        output match_result_t r);
        int     pos;
        bit     full;
        bit     found;
        int     best_slot;
        longint best;
        longint sum;
        r = '{default: '0};
        if (vec_pos == 0) begin
            if (op >= OP_RESET) begin
                r.slot = SLOT_FIELD_W'(sl);
                if (op == OP_RESET && present_f[sl]) begin
                    enrolled_f[sl] = 0;
                    quality_f[sl]  = '0;
                    r.accepted     = 1;
                end else if (op == OP_REMOVE && present_f[sl]) begin
                    present_f[sl]  = 0;
                    enrolled_f[sl] = 0;
                    quality_f[sl]  = '0;
                    r.accepted     = 1;
                end else if (op == OP_ADD && !present_f[sl]) begin
                    present_f[sl] = 1;
                    r.accepted    = 1;
                end
                return 1;
            end
            held_op   = op;
            held_slot = sl;
            held_qual = q;
            write_ok  = 0;
            if (op == OP_ASSIGN)
                write_ok = 1;
            else if (op == OP_IMPROVE && present_f[sl])
                write_ok = !enrolled_f[sl] ||
                           (longint'(q) * Q_NUM > longint'(quality_f[sl]) * Q_DEN);
            else if (op == OP_IDENTIFY)
                foreach (score_acc[s]) score_acc[s] = 0;
            if (write_ok)
                enrolled_f[sl] = 0;
        end

        pos = vec_pos;
        if (held_op != OP_IDENTIFY) begin
            if (write_ok)
                gallery_mem[held_slot][pos] = ev;
        end else begin
            for (int s = 0; s < SLOTS; s++) begin
                if (enrolled_f[s]) begin
                    sum = score_acc[s] + longint'(ev) * longint'(gallery_mem[s][pos]);
                    if (sum > longint'(ACC_MAX)) sum = ACC_MAX;
                    if (sum < longint'(ACC_MIN)) sum = ACC_MIN;
                    score_acc[s] = sum;
                end
            end
        end

        if (!lst && pos < DIM - 1) begin
            vec_pos = pos + 1;
            return 0;
        end
        vec_pos = 0;
        full    = (pos == DIM - 1);

        if (held_op == OP_IDENTIFY) begin
            // first strict maximum wins, starting from -1.0
            best      = MINUS_ONE_Q30;
            found     = 0;
            best_slot = 0;
            if (full) begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (enrolled_f[s] && score_acc[s] > best) begin
                        best      = score_acc[s];
                        best_slot = s;
                        found     = 1;
                    end
                end
            end
            r.slot     = SLOT_FIELD_W'(best_slot);
            r.accepted = full;
            if (found && best >= thr_q30) begin
                r.sim     = ACC_W'(best);
                r.matched = 1;
            end
            return 1;
        end

        if (write_ok) begin
            if (full) begin
                present_f[held_slot]  = 1;
                enrolled_f[held_slot] = 1;
                quality_f[held_slot]  = held_qual;
            end else begin
                quality_f[held_slot] = '0;
            end
        end
        r.slot     = SLOT_FIELD_W'(held_slot);
        r.accepted = write_ok && full;
        write_ok   = 0;
        return 1;
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of random length with random gaps. Acceptance is
    // judged on the stable stall seen at the falling edge before the
    // capturing rising edge.
    // ---------------------------------------------------------------
    task automatic send_beat(input t_op op, input int sl, input int ev, input int q,
                             input bit lst, input bit use_typed,
                             input match_result_t typed_r);
        match_result_t r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_slot          <= SLOT_FIELD_W'(sl);
        i_element_value <= EL_W'(ev);
        i_quality       <= QUAL_W'(q);
        i_last_element  <= lst;
        do @(negedge i_clk); while (o_in_stall);
        beats_in++;
        if (gallery_step(op, sl, EL_W'(ev), QUAL_W'(q), lst, r))
            pending_results.insert(pending_results.size(), use_typed ? typed_r : r);
        @(posedge i_clk);
    endtask

    // waits until every result is out, then lets the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_threshold(input longint value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= THR_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        thr_q30 = longint'($signed(i_cfg_wr_data));
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall with a randomly redrawn duty, plus one long
    // hold-off on request.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : out_stall_gen
        int hold_left;
        int duty;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            duty = 0;
        end else begin
            if (hold_request) begin
                hold_left    = HOLD_LEN;
                hold_request = 0;
            end
            if (cycles % 400 == 0) begin
                case ($urandom_range(0, 3))
                    0: duty = 0;
                    1: duty = 20;
                    2: duty = 50;
                    default: duty = 85;
                endcase
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < duty);
            end
        end
    end

    // result checker: beat accepted at the coming rising edge
    always @(negedge i_clk) begin
        match_result_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_matched) matches_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: slot %0d sim %0d m %0b a %0b",
                             o_result_slot, o_similarity, o_matched, o_accepted);
            end else begin
                e = pending_results.pop_front();
                if (o_result_slot !== e.slot || o_similarity !== e.sim ||
                    o_matched !== e.matched || o_accepted !== e.accepted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp slot %0d sim %0d m %0b a %0b, ",
                                  "got slot %0d sim %0d m %0b a %0b"},
                                 e.slot, e.sim, e.matched, e.accepted,
                                 o_result_slot, o_similarity, o_matched, o_accepted);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    dir_row_t dir_rows[$];

    function automatic dir_row_t mk_row(input t_op op, input int sl, input int len,
                                        input int ev, input int q, input bit no_last,
                                        input bit typed, input int w_slot,
                                        input longint w_sim, input bit w_m, input bit w_a);
        dir_row_t d;
        d.op = op; d.slot = sl; d.len = len; d.ev = ev; d.qual = q;
        d.no_last = no_last; d.typed = typed;
        d.want.slot = SLOT_FIELD_W'(w_slot); d.want.sim = ACC_W'(w_sim);
        d.want.matched = w_m; d.want.accepted = w_a;
        return d;
    endfunction

    function automatic void add_row(input dir_row_t d);
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    initial begin : stim
        match_result_t none_r;
        int     kind;
        int     len;
        int     src;
        int     sh;
        int     ev;
        int     q;
        int     sl;
        int     base;
        bit     lst;
        bit     no_last;
        bit     copy_src;
        t_op    op;
        logic signed [EL_W-1:0] raw;
        longint thr_set[5];

        none_r = '{default: '0};
        mismatches = 0; beats_in = 0; results_seen = 0; matches_seen = 0;
        cycles = 0; hold_request = 0; burst_left = 0;
        foreach (present_f[s]) begin
            present_f[s] = 0; enrolled_f[s] = 0; quality_f[s] = '0; score_acc[s] = 0;
        end
        vec_pos = 0; write_ok = 0; held_op = OP_ASSIGN; held_slot = 0; held_qual = '0;
        thr_q30 = THRESH_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; typed-in results where the answer is plain
        add_row(mk_row(OP_REMOVE, 5, 1, 0, 0, 0, 1, 5, 0, 0, 0));
        add_row(mk_row(OP_RESET, 5, 1, 0, 0, 0, 1, 5, 0, 0, 0));
        add_row(mk_row(OP_ADD, 5, 1, 0, 0, 0, 1, 5, 0, 0, 1));
        add_row(mk_row(OP_ADD, 5, 1, 0, 0, 0, 1, 5, 0, 0, 0));
        add_row(mk_row(t_op'(6), 9, 1, 0, 0, 0, 1, 9, 0, 0, 0));
        add_row(mk_row(t_op'(7), 63, 1, 0, 0, 0, 1, 63, 0, 0, 0));
        // empty gallery: full identify, no match
        add_row(mk_row(OP_IDENTIFY, 0, DIM, 32767, 0, 0, 1, 0, 0, 0, 1));
        // long vector with no last flag
        add_row(mk_row(OP_ASSIGN, 63, DIM, -32768, 65535, 1, 1, 63, 0, 0, 1));
        // improve refused: quality not 15% better
        add_row(mk_row(OP_IMPROVE, 63, DIM, 1, 65535, 0, 1, 63, 0, 0, 0));
        add_row(mk_row(OP_IMPROVE, 5, DIM, 16384, 0, 0, 1, 5, 0, 0, 1));
        add_row(mk_row(OP_IMPROVE, 5, DIM, 32767, 1, 0, 1, 5, 0, 0, 1));
        // saturating self score on slot 63
        add_row(mk_row(OP_IDENTIFY, 0, DIM, -32768, 0, 0, 1, 63, ACC_MAX, 1, 1));
        // short identify aborts
        add_row(mk_row(OP_IDENTIFY, 0, 2, 100, 0, 0, 1, 0, 0, 0, 0));
        // short granted assign leaves slot un-enrolled
        add_row(mk_row(OP_ASSIGN, 5, 1, -1, 77, 0, 1, 5, 0, 0, 0));
        add_row(mk_row(OP_IMPROVE, 20, DIM, 5, 9, 0, 1, 20, 0, 0, 0));
        add_row(mk_row(OP_RESET, 63, 1, 0, 0, 0, 1, 63, 0, 0, 1));
        add_row(mk_row(OP_REMOVE, 63, 1, 0, 0, 0, 1, 63, 0, 0, 1));
        add_row(mk_row(OP_IDENTIFY, 0, DIM, 0, 0, 0, 1, 0, 0, 0, 1));

        foreach (dir_rows[i]) begin
            for (int k = 0; k < dir_rows[i].len; k++) begin
                lst = (k == dir_rows[i].len - 1) && !dir_rows[i].no_last;
                send_beat(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].ev,
                          dir_rows[i].qual, lst, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        thr_set[0] = -(64'sd1 <<< 30);
        thr_set[1] = 64'sd1 <<< 30;
        thr_set[2] = 0;
        thr_set[3] = THRESH_RESET;
        thr_set[4] = $urandom_range(0, 1 << 30) - (1 << 29);

        // random phases, each under its own threshold
        base = beats_in;
        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(ph < 5 ? thr_set[ph] : $urandom_range(0, 1 << 30));
            if (ph == 2) begin
                // long output hold-off while single ops keep coming
                hold_request = 1;
                repeat (40) send_beat(t_op'($urandom_range(3, 7)), $urandom_range(0, 63),
                                      $urandom, $urandom, $urandom_range(0, 1), 0, none_r);
            end
            while (beats_in - base < PHASE_BEATS * (ph + 1) ||
                   results_seen < 12 * (ph + 1)) begin
                kind = $urandom_range(0, 99);
                if (kind < 38) begin
                    send_beat(t_op'($urandom_range(3, 7)), $urandom_range(0, 15), $urandom,
                              $urandom, $urandom_range(0, 1), 0, none_r);
                end else begin
                    if (kind < 62) op = t_op'($urandom_range(0, 1));
                    else if (kind < 72) op = OP_IDENTIFY;
                    else op = t_op'($urandom_range(0, 2));
                    len      = (kind < 72) ? DIM : $urandom_range(1, 8);
                    no_last  = (len == DIM) && ($urandom_range(0, 5) == 0);
                    sl       = $urandom_range(0, 15);
                    src      = $urandom_range(0, 15);
                    copy_src = enrolled_f[src] && ($urandom_range(0, 2) != 0);
                    sh       = $urandom_range(0, 4);
                    sh       = (sh == 0) ? 0 : sh + 2;
                    // improve quality near the 15% boundary half of the time
                    if ($urandom_range(0, 1))
                        q = (int'(quality_f[sl]) * Q_DEN) / Q_NUM + $urandom_range(0, 2) - 1;
                    else
                        q = $urandom;
                    for (int k = 0; k < len; k++) begin
                        raw = EL_W'($urandom);
                        ev  = copy_src ? gallery_mem[src][k] + (int'($urandom_range(0, 6)) - 3)
                                       : raw >>> sh;
                        lst = (k == len - 1) && !no_last;
                        if (k == 0)
                            send_beat(op, sl, ev, q, lst, 0, none_r);
                        else
                            // inside a vector the op and slot fields mean nothing
                            send_beat(t_op'($urandom_range(0, 7)), $urandom_range(0, 63), ev,
                                      $urandom, lst, 0, none_r);
                    end
                end
            end
        end

        wait_drained();
        $display("run covered %0d input beats, %0d result beats (%0d matches)",
                 beats_in, results_seen, matches_seen);
        $display("six threshold settings including both extremes, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/embgm_pkg.sv
rtl/core/embgm_mac.sv
rtl/core/embedding_gallery_matcher.sv
tb/tb.sv
